// ===== rtl/core/binomial_pascal_row_assert.svh =====
// Assertion macros used by the checker file of the row engine.
`ifndef BINOMIAL_PASCAL_ROW_ASSERT_SVH
`define BINOMIAL_PASCAL_ROW_ASSERT_SVH

// Same-cycle implication, muted while reset is held.
`define BPR_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("binomial row check failed");

// Next-cycle implication, muted while reset is held.
`define BPR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("binomial row check failed");

`endif

// ===== rtl/core/bpr_pkg.sv =====
// ----------------------------------------------------------------------------
// bpr_pkg
// Shared widths, result selects and the controller-to-datapath command beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bpr_pkg;

    localparam int VALUE_W = 63;   // coefficient width
    localparam int N_W     = 7;    // request field width
    localparam int ROW_W   = 8;    // row counter, holds n + 1

    typedef enum logic [1:0] {
        RES_ZERO,
        RES_SAT,
        RES_MEM
    } t_res_sel;

    typedef struct packed {
        logic     rd_en;     // read entries col and col-1
        logic     wb_en;     // write the sum back to col next cycle
        logic     clr_en;    // initialize entry col
        logic     clr_one;   // initialize to one instead of zero
        logic     ovf_clr;   // drop the overflow flag of the last request
        logic     res_load;  // latch the result beat
        t_res_sel res_sel;
    } t_dp_cmd;

endpackage

// ===== rtl/core/bpr_datapath.sv =====
// ----------------------------------------------------------------------------
// bpr_datapath
// Row store with two registered read ports, saturating adder, write-back
// stage and result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bpr_datapath #(
    parameter int ROW_DEPTH = 64,
    localparam int AW = (ROW_DEPTH > 1) ? $clog2(ROW_DEPTH) : 1
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  bpr_pkg::t_dp_cmd             i_cmd,
    input  logic [AW-1:0]                i_col,
    output logic [bpr_pkg::VALUE_W-1:0]  o_coefficient,
    output logic                         o_overflow
);
    import bpr_pkg::*;

    logic [VALUE_W-1:0] mem [ROW_DEPTH];
    logic [VALUE_W-1:0] r_rd_a;
    logic [VALUE_W-1:0] r_rd_b;
    logic               r_wb_vld;
    logic [AW-1:0]      r_wb_addr;
    logic               r_ovf;
    logic [VALUE_W-1:0] r_coef;
    logic               r_res_ovf;
    logic [AW-1:0]      col_m1;
    logic [VALUE_W:0]   sum;
    logic [VALUE_W-1:0] sum_sat;

    assign col_m1  = i_col - AW'(1);
    assign sum     = {1'b0, r_rd_a} + {1'b0, r_rd_b};
    assign sum_sat = sum[VALUE_W] ? {VALUE_W{1'b1}} : sum[VALUE_W-1:0];

    // Write port: initialize entries, else retire the pending sum
    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_en) begin
            mem[i_col] <= i_cmd.clr_one ? VALUE_W'(1) : '0;
        end else if (r_wb_vld) begin
            mem[r_wb_addr] <= sum_sat;
        end
    end

    // Read ports: entry col and its left neighbor
    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_en) begin
            r_rd_a <= mem[i_col];
            if (i_col != '0) begin
                r_rd_b <= mem[col_m1];
            end
        end
        r_wb_addr <= i_col;
    end

    // Track the pending write-back and the overflow flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wb_vld <= 1'b0;
            r_ovf    <= 1'b0;
        end else begin
            r_wb_vld <= i_cmd.wb_en;
            if (i_cmd.ovf_clr) begin
                r_ovf <= 1'b0;
            end else if (r_wb_vld && sum[VALUE_W]) begin
                r_ovf <= 1'b1;
            end
        end
    end

    // Hold the result beat
    always_ff @(posedge i_clk) begin
        if (i_cmd.res_load) begin
            unique case (i_cmd.res_sel)
                RES_ZERO: begin
                    r_coef    <= '0;
                    r_res_ovf <= 1'b0;
                end
                RES_SAT: begin
                    r_coef    <= {VALUE_W{1'b1}};
                    r_res_ovf <= 1'b1;
                end
                RES_MEM: begin
                    r_coef    <= r_rd_a;
                    r_res_ovf <= r_ovf;
                end
                default: begin
                    r_coef    <= '0;
                    r_res_ovf <= 1'b0;
                end
            endcase
        end
    end

    assign o_coefficient = r_coef;
    assign o_overflow    = r_res_ovf;

endmodule

// ===== rtl/core/bpr_ctrl.sv =====
// ----------------------------------------------------------------------------
// bpr_ctrl
// Sequencer: range checks, row clear sweep, row and column walk, result read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bpr_ctrl #(
    parameter int MAX_N     = 127,
    parameter int ROW_DEPTH = 64,
    localparam int AW = (ROW_DEPTH > 1) ? $clog2(ROW_DEPTH) : 1
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     start,
    input  logic [bpr_pkg::N_W-1:0]  i_set_size,
    input  logic [bpr_pkg::N_W-1:0]  i_pick_count,
    output logic                     busy,
    output logic                     o_done,
    output bpr_pkg::t_dp_cmd         o_cmd,
    output logic [AW-1:0]            o_col
);
    import bpr_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CLEAR,
        S_ROW,
        S_COL,
        S_READ,
        S_FIN
    } t_state;

    t_state           r_state;
    logic [N_W-1:0]   r_n;
    logic [AW-1:0]    r_r;
    logic [ROW_W-1:0] r_row;
    logic [AW-1:0]    r_col;
    logic             r_done;

    logic [N_W-1:0]   diff;
    logic [N_W-1:0]   red_pick;
    logic             pick_gt_set;
    logic             cap_fail;
    logic [AW-1:0]    top;
    logic             accept;

    // Reduce the pick and check capacity
    assign accept      = start && (r_state == S_IDLE);
    assign pick_gt_set = i_set_size < i_pick_count;
    assign diff        = i_set_size - i_pick_count;
    assign red_pick    = (diff < i_pick_count) ? diff : i_pick_count;
    assign cap_fail    = (ROW_W'(i_set_size) > ROW_W'(MAX_N))
                      || (ROW_W'(red_pick) >= ROW_W'(ROW_DEPTH));

    // Last column of the current row
    assign top = (r_row < ROW_W'(r_r)) ? r_row[AW-1:0] : r_r;

    // Decode commands from state
    always_comb begin
        o_cmd = '0;
        o_cmd.res_sel = RES_MEM;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    o_cmd.ovf_clr  = 1'b1;
                    o_cmd.res_load = pick_gt_set || cap_fail;
                    o_cmd.res_sel  = pick_gt_set ? RES_ZERO : RES_SAT;
                end
            end
            S_CLEAR: begin
                o_cmd.clr_en  = 1'b1;
                o_cmd.clr_one = (r_col == '0);
            end
            S_ROW: begin
            end
            S_COL: begin
                o_cmd.rd_en = 1'b1;
                o_cmd.wb_en = 1'b1;
            end
            S_READ: begin
                o_cmd.rd_en = 1'b1;
            end
            S_FIN: begin
                o_cmd.res_load = 1'b1;
                o_cmd.res_sel  = RES_MEM;
            end
            default: begin
            end
        endcase
    end

    // Advance state, counters and the result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_n     <= '0;
            r_r     <= '0;
            r_row   <= '0;
            r_col   <= '0;
            r_done  <= 1'b0;
        end else begin
            // strobe after a refused request or after the final read
            r_done <= (r_state == S_FIN)
                   || (accept && (pick_gt_set || cap_fail));
            unique case (r_state)
                S_IDLE: begin
                    if (accept && !(pick_gt_set || cap_fail)) begin
                        r_n     <= i_set_size;
                        r_r     <= red_pick[AW-1:0];
                        r_col   <= '0;
                        r_state <= S_CLEAR;
                    end
                end
                S_CLEAR: begin
                    if (r_col == r_r) begin
                        r_row   <= ROW_W'(1);
                        r_state <= S_ROW;
                    end else begin
                        r_col <= r_col + AW'(1);
                    end
                end
                S_ROW: begin
                    if (r_row > ROW_W'(r_n)) begin
                        r_col   <= r_r;
                        r_state <= S_READ;
                    end else if (top == '0) begin
                        r_row <= r_row + ROW_W'(1);
                    end else begin
                        r_col   <= top;
                        r_state <= S_COL;
                    end
                end
                S_COL: begin
                    if (r_col == AW'(1)) begin
                        r_row   <= r_row + ROW_W'(1);
                        r_state <= S_ROW;
                    end else begin
                        r_col <= r_col - AW'(1);
                    end
                end
                S_READ: begin
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign busy   = (r_state != S_IDLE);
    assign o_done = r_done;
    assign o_col  = r_col;

endmodule

// ===== rtl/core/binomial_pascal_row.sv =====
// ----------------------------------------------------------------------------
// binomial_pascal_row
// Binomial coefficient C(n, r) by in-place Pascal row update with 63-bit
// saturating sums.
//
//   channel   signals                              direction
//   request   start, busy, i_set_size, i_pick_count  in  (start & !busy)
//   result    o_done, o_coefficient, o_overflow      out (one-cycle strobe)
//
// A request with r > n or beyond capacity answers in the cycle after start.
// Otherwise, with r' = min(r, n - r), the sweep clears entries 0..r', the walk
// updates row i = 1..n from column min(i, r') down to 1, then reads entry r';
// the row walk is bound by one read-add-write of the row store per column.
// busy is high after an in-range request is taken, until the strobe cycle.
// Reset is synchronous and needs no clearing pass; results cannot be stalled.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module binomial_pascal_row #(
    parameter int MAX_N     = 127,
    parameter int ROW_DEPTH = 64
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [bpr_pkg::N_W-1:0]      i_set_size,
    input  logic [bpr_pkg::N_W-1:0]      i_pick_count,
    output logic                         o_done,
    output logic [bpr_pkg::VALUE_W-1:0]  o_coefficient,
    output logic                         o_overflow
);
    import bpr_pkg::*;

    localparam int AW = (ROW_DEPTH > 1) ? $clog2(ROW_DEPTH) : 1;

    t_dp_cmd       cmd;
    logic [AW-1:0] col;

    // Sequencer
    bpr_ctrl #(
        .MAX_N     (MAX_N),
        .ROW_DEPTH (ROW_DEPTH)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .i_set_size   (i_set_size),
        .i_pick_count (i_pick_count),
        .busy         (busy),
        .o_done       (o_done),
        .o_cmd        (cmd),
        .o_col        (col)
    );

    // Row store and adder
    bpr_datapath #(
        .ROW_DEPTH (ROW_DEPTH)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_col         (col),
        .o_coefficient (o_coefficient),
        .o_overflow    (o_overflow)
    );

endmodule

// ===== rtl/core/bpr_checker.sv =====
// ----------------------------------------------------------------------------
// bpr_checker
// Port-level checks on request acceptance, result timing and saturation.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "binomial_pascal_row_assert.svh"

module bpr_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_start,
    input logic                         i_busy,
    input logic                         i_done,
    input logic [bpr_pkg::VALUE_W-1:0]  i_coefficient,
    input logic                         i_overflow
);
    import bpr_pkg::*;

    // An accepted beat either answers at once or keeps the block busy
    `BPR_ASSERT_NEXT(a_accept_progress, i_clk, i_rst_n, i_start && !i_busy, i_busy || i_done)

    // The end of a long request always carries its result beat
    `BPR_ASSERT_IMPL(a_busy_end_done, i_clk, i_rst_n, $fell(i_busy), i_done)

    // No result beat while a request is still at work
    `BPR_ASSERT_IMPL(a_done_idle, i_clk, i_rst_n, i_done, !i_busy)

    // Overflow always comes with the saturated coefficient
    `BPR_ASSERT_IMPL(a_ovf_sat, i_clk, i_rst_n, i_done && i_overflow, &i_coefficient)

endmodule

bind binomial_pascal_row bpr_checker u_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_start       (start),
    .i_busy        (busy),
    .i_done        (o_done),
    .i_coefficient (o_coefficient),
    .i_overflow    (o_overflow)
);

// ===== verif/binomial_pascal_row_tb.sv =====
// ----------------------------------------------------------------------------
// binomial_pascal_row_tb
// Self-checking bench for the Pascal-row binomial engine. A scoreboard class
// rebuilds each row in place with 63-bit saturating sums. It queues the
// expected coefficient and overflow flag for every request beat the block
// accepts, and compares each strobed result against the oldest entry.
// Stimulus covers directed corner requests first, then a random mix. The mix
// is weighted to short rows, with some wide rows near the overflow boundary
// and random sender gaps.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

class coeff_scoreboard;

    localparam int MAX_N     = 127;
    localparam int ROW_DEPTH = 64;

    typedef logic [bpr_pkg::VALUE_W-1:0] t_coeff;
    localparam t_coeff COEFF_SAT = '1;

    // working copy of the row store
    t_coeff row [ROW_DEPTH];
    t_coeff exp_coeff [$];
    bit     exp_ovf [$];
    int     errors;

    function int pending();
        return exp_coeff.size();
    endfunction

    // Build C(n, r) the way the block does and queue the outcome.
    function void note_request(logic [bpr_pkg::N_W-1:0] n_in,
                               logic [bpr_pkg::N_W-1:0] r_in);
        int unsigned n;
        int unsigned r;
        int unsigned top;
        int unsigned i;
        int unsigned j;
        logic [bpr_pkg::VALUE_W:0] sum;
        t_coeff coef;
        bit ovf;
        n   = 32'(n_in);
        r   = 32'(r_in);
        ovf = 1'b0;
        if (n < r) begin
            coef = '0;
        end else begin
            if (n - r < r) r = n - r;
            if (n > MAX_N || r + 1 > ROW_DEPTH) begin
                // row does not fit: answer saturated
                coef = COEFF_SAT;
                ovf  = 1'b1;
            end else begin
                for (j = 0; j <= r; j++) row[j] = '0;
                row[0] = t_coeff'(1);
                for (i = 1; i <= n; i++) begin
                    top = (i < r) ? i : r;
                    // walk columns downward so entry j-1 is still the old row
                    for (j = top; j > 0; j--) begin
                        sum = {1'b0, row[j]} + {1'b0, row[j-1]};
                        if (sum[bpr_pkg::VALUE_W]) begin
                            row[j] = COEFF_SAT;
                            ovf    = 1'b1;
                        end else begin
                            row[j] = sum[bpr_pkg::VALUE_W-1:0];
                        end
                    end
                end
                coef = row[r];
            end
        end
        exp_coeff = {exp_coeff, coef};
        exp_ovf   = {exp_ovf, ovf};
    endfunction

    // Compare one result beat with the oldest expectation.
    function void check_result(t_coeff coef, logic ovf);
        t_coeff want_coef;
        bit     want_ovf;
        if (exp_coeff.size() == 0) begin
            $display("%0t unexpected result: coefficient %0d overflow %0b",
                     $time, coef, ovf);
            errors++;
            return;
        end
        want_coef = exp_coeff.pop_front();
        want_ovf  = exp_ovf.pop_front();
        if (coef !== want_coef) begin
            $display("%0t coefficient mismatch: expected %0d actual %0d",
                     $time, want_coef, coef);
            errors++;
        end
        if (ovf !== want_ovf) begin
            $display("%0t overflow mismatch: expected %0b actual %0b",
                     $time, want_ovf, ovf);
            errors++;
        end
    endfunction

endclass

module binomial_pascal_row_tb;

    localparam int N_W = bpr_pkg::N_W;

    logic                        i_clk = 1'b0;
    logic                        i_rst_n = 1'b0;
    logic                        start = 1'b0;
    logic                        busy;
    logic [N_W-1:0]              i_set_size = '0;
    logic [N_W-1:0]              i_pick_count = '0;
    logic                        o_done;
    logic [bpr_pkg::VALUE_W-1:0] o_coefficient;
    logic                        o_overflow;

    coeff_scoreboard sb = new();
    bit no_idle = 1'b0;

    binomial_pascal_row #(
        .MAX_N     (127),
        .ROW_DEPTH (64)
    ) DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_set_size    (i_set_size),
        .i_pick_count  (i_pick_count),
        .o_done        (o_done),
        .o_coefficient (o_coefficient),
        .o_overflow    (o_overflow)
    );

    always #6 i_clk = ~i_clk;

    // Present one request beat and hold it until the block takes it.
    task automatic send_request(input logic [N_W-1:0] n, input logic [N_W-1:0] r);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start        <= 1'b1;
        i_set_size   <= n;
        i_pick_count <= r;
        do @(posedge i_clk); while (!(start && !busy));
        sb.note_request(n, r);
    endtask

    // Drop start and hold off until every queued result has come back.
    task automatic drain_results();
        start <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() > 0) @(posedge i_clk);
    endtask

    // Check every result beat.
    always @(posedge i_clk) begin
        if (i_rst_n && o_done) sb.check_result(o_coefficient, o_overflow);
    end

    initial begin
        logic [N_W-1:0] n;
        logic [N_W-1:0] r;
        int sel;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed corners: empty set, full pick, pick above set,
        // widest row, and both sides of the 63-bit overflow boundary
        send_request(7'd0, 7'd0);
        send_request(7'd127, 7'd0);
        send_request(7'd127, 7'd127);
        send_request(7'd1, 7'd0);
        send_request(7'd1, 7'd1);
        send_request(7'd5, 7'd7);
        send_request(7'd0, 7'd127);
        send_request(7'd126, 7'd127);
        send_request(7'd10, 7'd3);
        send_request(7'd10, 7'd7);
        send_request(7'd127, 7'd1);
        send_request(7'd127, 7'd126);
        send_request(7'd62, 7'd31);
        send_request(7'd66, 7'd33);
        send_request(7'd67, 7'd33);
        send_request(7'd67, 7'd34);
        send_request(7'd126, 7'd63);
        send_request(7'd127, 7'd63);
        send_request(7'd127, 7'd64);
        send_request(7'd85, 7'd42);
        drain_results();

        // random mix, mostly short rows
        for (int k = 0; k < 120; k++) begin
            if (k % 20 == 0) no_idle = ($urandom_range(0, 2) == 0);
            if (k == 60) drain_results();
            sel = $urandom_range(0, 99);
            if (sel < 60) begin
                n = N_W'($urandom_range(0, 40));
                r = N_W'($urandom_range(0, n + 4));
            end else if (sel < 75) begin
                n = N_W'($urandom_range(0, 127));
                r = N_W'($urandom_range(0, 127));
            end else if (sel < 88) begin
                // wide rows around the middle column
                n = N_W'($urandom_range(60, 127));
                r = N_W'($urandom_range(n / 2 - 3, n / 2 + 3));
            end else begin
                n = N_W'($urandom_range(41, 127));
                r = N_W'($urandom_range(0, 1) ? $urandom_range(0, 3)
                                              : n - $urandom_range(0, 3));
            end
            send_request(n, r);
        end

        drain_results();
        repeat (20) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    // Stop a hung run.
    initial begin
        #(64'd60_000_000);
        $display("FAIL");
        $finish;
    end

endmodule
